FILE: design/ial_pkg.sv
// Shared types, codes and defaults for the indexed array list.
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W    = 2;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT_VAL,
        S_READ_MEM,
        S_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the request and seed the pointer
        logic rd_shift;  // read the neighbor of the pointer
        logic wr_shift;  // write the read word at the pointer and step it
        logic wr_val;    // write the request value at the pointer
        logic rd_one;    // read the entry named by the request
        logic finish;    // load the result register and commit the length
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        req_t req;
        logic bad;
        logic full;
        logic at_end;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

FILE: design/ial_ctrl.sv
// Request sequencer for the indexed array list.
`timescale 1ns / 1ps
`default_nettype none

module ial_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ial_pkg::stat_t stat,
    output ial_pkg::cmd_t      cmd
);

    ial_pkg::state_t state_reg;
    ial_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ial_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ial_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ial_pkg::S_DECIDE;
                end
            end
            ial_pkg::S_DECIDE:
            begin
                if (stat.bad || stat.full)
                begin
                    state_next = ial_pkg::S_FINISH;
                end
                else if (stat.req == ial_pkg::REQ_READ)
                begin
                    state_next = ial_pkg::S_READ_MEM;
                end
                else
                begin
                    state_next = ial_pkg::S_SHIFT_RD;
                end
            end
            ial_pkg::S_SHIFT_RD:
            begin
                if (!stat.at_end)
                begin
                    state_next = ial_pkg::S_SHIFT_WR;
                end
                else if (stat.req == ial_pkg::REQ_ERASE)
                begin
                    state_next = ial_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ial_pkg::S_PUT_VAL;
                end
            end
            ial_pkg::S_SHIFT_WR: state_next = ial_pkg::S_SHIFT_RD;
            ial_pkg::S_PUT_VAL:  state_next = ial_pkg::S_FINISH;
            ial_pkg::S_READ_MEM: state_next = ial_pkg::S_FINISH;
            ial_pkg::S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ial_pkg::S_IDLE;
                end
            end
            default: state_next = ial_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ial_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ial_pkg::S_SHIFT_RD: cmd.rd_shift = !stat.at_end;
            ial_pkg::S_SHIFT_WR: cmd.wr_shift = 1'b1;
            ial_pkg::S_PUT_VAL:  cmd.wr_val   = 1'b1;
            ial_pkg::S_READ_MEM: cmd.rd_one   = 1'b1;
            ial_pkg::S_FINISH:   cmd.finish   = !stat.out_busy;
            default:             cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/ial_datapath.sv
// Entry store, length counter, shift pointer and result register.
`timescale 1ns / 1ps
`default_nettype none

module ial_datapath
#(
    parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ial_pkg::REQ_W-1:0]      req_type,
    input  wire logic [ial_pkg::INDEX_W-1:0]    index,
    input  wire logic [ial_pkg::VALUE_W-1:0]    value,
    input  wire ial_pkg::cmd_t                  cmd,
    output ial_pkg::stat_t                      stat,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ial_pkg::VALUE_W-1:0]         read_value,
    output logic [ial_pkg::LENGTH_W-1:0]        list_length,
    output logic [ial_pkg::STATUS_W-1:0]        status
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > ial_pkg::INDEX_W) ? CW : ial_pkg::INDEX_W;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    ial_pkg::req_t           req_reg;
    logic [ial_pkg::INDEX_W-1:0] index_reg;
    logic [DATA_WIDTH-1:0]   value_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [AW-1:0]           ptr_reg;
    logic [DATA_WIDTH-1:0]   rdata_reg;

    logic                        out_valid_reg;
    logic [ial_pkg::VALUE_W-1:0] read_value_reg;
    logic [ial_pkg::LENGTH_W-1:0] list_length_reg;
    ial_pkg::status_t            status_reg;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] ptr_ext;
    logic [AW-1:0]    src_addr;
    logic [AW-1:0]    pos_addr;
    logic [63:0]      value_wide;
    logic [63:0]      rdata_wide;
    ial_pkg::status_t result_status;
    logic             bad;
    logic             full;

    assign pos_ext  = CMP_W'(index_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign ptr_ext  = CMP_W'(ptr_reg);
    assign pos_addr = pos_ext[AW-1:0];
    assign src_addr = (req_reg == ial_pkg::REQ_INSERT) ? ptr_reg - 1'b1 : ptr_reg + 1'b1;

    assign value_wide = 64'(value);
    assign rdata_wide = 64'(rdata_reg);

    always_comb
    begin
        bad  = 1'b0;
        full = 1'b0;
        unique case (req_reg)
            ial_pkg::REQ_INSERT:
            begin
                bad  = pos_ext > cnt_ext;
                full = count_reg == CW'(CAPACITY);
            end
            ial_pkg::REQ_APPEND: full = count_reg == CW'(CAPACITY);
            ial_pkg::REQ_ERASE:  bad  = pos_ext >= cnt_ext;
            ial_pkg::REQ_READ:   bad  = pos_ext >= cnt_ext;
            default:             bad  = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (bad)
        begin
            result_status = ial_pkg::ST_BAD_INDEX;
        end
        else if (full)
        begin
            result_status = ial_pkg::ST_FULL;
        end
        else
        begin
            result_status = ial_pkg::ST_OK;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (result_status == ial_pkg::ST_OK)
        begin
            unique case (req_reg)
                ial_pkg::REQ_INSERT: count_next = count_reg + 1'b1;
                ial_pkg::REQ_APPEND: count_next = count_reg + 1'b1;
                ial_pkg::REQ_ERASE:  count_next = count_reg - 1'b1;
                ial_pkg::REQ_READ:   count_next = count_reg;
                default:             count_next = count_reg;
            endcase
        end
    end

    assign stat.req      = req_reg;
    assign stat.bad      = bad;
    assign stat.full     = full;
    assign stat.at_end   = (req_reg == ial_pkg::REQ_APPEND)
                        || ((req_reg == ial_pkg::REQ_INSERT) && (ptr_ext == pos_ext))
                        || ((req_reg == ial_pkg::REQ_ERASE) && (ptr_ext + 1'b1 == cnt_ext));
    assign stat.out_busy = out_valid_reg && !out_ready;

    // request capture and shift pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= ial_pkg::req_t'(req_type);
            index_reg <= index;
            value_reg <= value_wide[DATA_WIDTH-1:0];
            if ((req_type == ial_pkg::REQ_INSERT) || (req_type == ial_pkg::REQ_APPEND))
            begin
                ptr_reg <= count_reg[AW-1:0];
            end
            else
            begin
                ptr_reg <= index[AW-1:0];
            end
        end
        else if (cmd.wr_shift)
        begin
            ptr_reg <= src_addr;
        end
    end

    // entry store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift)
        begin
            mem[ptr_reg] <= rdata_reg;
        end
        else if (cmd.wr_val)
        begin
            mem[ptr_reg] <= value_reg;
        end
        if (cmd.rd_shift)
        begin
            rdata_reg <= mem[src_addr];
        end
        else if (cmd.rd_one)
        begin
            rdata_reg <= mem[pos_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            list_length_reg <= ial_pkg::LENGTH_W'(count_next);
            status_reg      <= result_status;
            if ((req_reg == ial_pkg::REQ_READ) && (result_status == ial_pkg::ST_OK))
            begin
                read_value_reg <= rdata_wide[ial_pkg::VALUE_W-1:0];
            end
            else
            begin
                read_value_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign list_length = list_length_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

FILE: design/indexed_array_list_top.sv
// Top level of the indexed array list: sequencer plus datapath.
//
// Usage: an ordered list of up to CAPACITY words held in a single-port store.
// Input channel (in_valid/in_ready) carries one request: req_type, index, value.
// Insert places value at index and moves later entries up, append adds it at
// the end, erase removes the entry at index and moves later entries down, read
// returns the entry at index. Every request yields one result on the output
// channel (out_valid/out_ready): read_value, list_length and status.
// Each request is checked first; a rejected one goes straight to the result,
// a read reads one store entry and an append writes one. Insert and erase move
// the later entries one at a time; each moved entry costs one store read and
// one store write, since the store has one port.
// One request is in work at a time; the next is taken the cycle after the
// result register loads, while that result may still wait to be taken.
// A stalled receiver holds the result; the sequencer then waits in its last
// step until the result register is free.
// Reset empties the list and drops any pending result; the store itself is
// not cleared, only positions below the length are ever read.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_list_top
#(
    parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ial_pkg::REQ_W-1:0]      req_type,
    input  wire logic [ial_pkg::INDEX_W-1:0]    index,
    input  wire logic [ial_pkg::VALUE_W-1:0]    value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ial_pkg::VALUE_W-1:0]         read_value,
    output logic [ial_pkg::LENGTH_W-1:0]        list_length,
    output logic [ial_pkg::STATUS_W-1:0]        status
);

    ial_pkg::cmd_t  cmd;
    ial_pkg::stat_t stat;

    // sequencer: steps each request through decide, shift, write or read, and finish
    ial_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: store, length counter, pointer and result register
    ial_datapath
    #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .index       (index),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .list_length (list_length),
        .status      (status)
    );

    // one request at a time: acceptance closes the input until the result loads
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another was in work");

    // a result never carries an unused status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ial_pkg::ST_OK) || (status == ial_pkg::ST_BAD_INDEX)
                       || (status == ial_pkg::ST_FULL)))
        else $error("result carries an unused status code");

    // a full report means the list holds exactly CAPACITY entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ial_pkg::ST_FULL))
            |-> (list_length == ial_pkg::LENGTH_W'(CAPACITY)))
        else $error("full reported with a short list");

    // a failed request returns no data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ial_pkg::ST_OK)) |-> (read_value == '0))
        else $error("failed request returned data");

endmodule

`default_nettype wire

FILE: bench/tb_indexed_array_list_top.sv
// Self-checking bench for the indexed array list: random requests checked against a shadow list.
`timescale 1ns / 1ps

module tb_indexed_array_list_top;

    localparam int LIST_CAP   = ial_pkg::CAPACITY_DEF;
    localparam int RAND_ITEMS = 1750;

    // Random phases steer the request mix so the list fills, drains and
    // overflows instead of wandering around a small length.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN,
        MIX_FILL
    } mix_t;

    // Shadow copy of the list. It updates on every accepted request and
    // queues the result that request must produce.
    class list_shadow;
        typedef struct {
            logic [ial_pkg::VALUE_W-1:0]  word;
            logic [ial_pkg::LENGTH_W-1:0] length;
            ial_pkg::status_t             code;
        } result_t;

        logic [ial_pkg::VALUE_W-1:0] cells [LIST_CAP];
        int                          count;
        result_t                     expected_results [$];
        int                          fails;

        function new();
            count = 0;
            fails = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(ial_pkg::req_t kind, logic [ial_pkg::INDEX_W-1:0] idx,
                                   logic [ial_pkg::VALUE_W-1:0] val);
            result_t r;
            int      pos;
            r.word = '0;
            r.code = ial_pkg::ST_OK;
            pos    = (kind == ial_pkg::REQ_APPEND) ? count : int'(idx);
            case (kind)
                ial_pkg::REQ_INSERT, ial_pkg::REQ_APPEND:
                begin
                    // position check takes priority over the capacity check
                    if (pos > count)
                        r.code = ial_pkg::ST_BAD_INDEX;
                    else if (count >= LIST_CAP)
                        r.code = ial_pkg::ST_FULL;
                    else
                    begin
                        for (int i = count; i > pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos] = val;
                        count++;
                    end
                end
                ial_pkg::REQ_ERASE:
                begin
                    if (pos >= count)
                        r.code = ial_pkg::ST_BAD_INDEX;
                    else
                    begin
                        for (int i = pos; i + 1 < count; i++)
                            cells[i] = cells[i+1];
                        count--;
                    end
                end
                default:
                begin
                    if (pos >= count)
                        r.code = ial_pkg::ST_BAD_INDEX;
                    else
                        r.word = cells[pos];
                end
            endcase
            r.length = count[ial_pkg::LENGTH_W-1:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [ial_pkg::VALUE_W-1:0] word,
                                   logic [ial_pkg::LENGTH_W-1:0] length,
                                   logic [ial_pkg::STATUS_W-1:0] code);
            result_t r;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: read_value %h length %0d status %0d",
                         $time, word, length, code);
                fails++;
                return;
            end
            r = expected_results.pop_front();
            if (word !== r.word)
            begin
                $display("%0t: read_value expected %h actual %h", $time, r.word, word);
                fails++;
            end
            if (length !== r.length)
            begin
                $display("%0t: list_length expected %0d actual %0d", $time, r.length, length);
                fails++;
            end
            if (code !== r.code)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.code, code);
                fails++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [ial_pkg::REQ_W-1:0]    req_type;
    logic [ial_pkg::INDEX_W-1:0]  index;
    logic [ial_pkg::VALUE_W-1:0]  value;
    logic                         out_valid;
    logic                         out_ready;
    logic [ial_pkg::VALUE_W-1:0]  read_value;
    logic [ial_pkg::LENGTH_W-1:0] list_length;
    logic [ial_pkg::STATUS_W-1:0] status;

    // When set, neither side idles: back-to-back requests and an always-ready receiver.
    bit                  calm = 1'b0;

    list_shadow          shadow = new();

    indexed_array_list_top u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .index       (index),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .list_length (list_length),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every result on the edge it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_result(read_value, list_length, status);
    end

    // Receiver: stall a random number of cycles before each result, then hold
    // ready until the result is taken. Ready stays high across a zero stall.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Send one request: idle a random gap, present it, hold it until taken.
    // Called and returns at a falling edge. Valid is not dropped for a zero gap.
    task automatic send_request(ial_pkg::req_t kind, logic [ial_pkg::INDEX_W-1:0] idx,
                                logic [ial_pkg::VALUE_W-1:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = kind;
        index    = idx;
        value    = val;
        do @(posedge clk); while (!in_ready);
        shadow.note_request(kind, idx, val);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every outstanding result is back.
    task automatic drain_results();
        in_valid = 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [ial_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Any 7-bit position, in range or not.
    function automatic logic [ial_pkg::INDEX_W-1:0] any_index();
        return ial_pkg::INDEX_W'($urandom_range(0, 127));
    endfunction

    // Pick a position: mostly one that the request can use, now and then any
    // 7-bit value so out-of-range positions keep showing up.
    function automatic logic [ial_pkg::INDEX_W-1:0] pick_index(ial_pkg::req_t kind);
        int n;
        n = shadow.count;
        if ($urandom_range(0, 7) == 0)
            return any_index();
        if (kind == ial_pkg::REQ_INSERT)
            return ial_pkg::INDEX_W'($urandom_range(0, n));
        return (n == 0) ? '0 : ial_pkg::INDEX_W'($urandom_range(0, n - 1));
    endfunction

    function automatic ial_pkg::req_t pick_kind(mix_t mix);
        int r;
        r = $urandom_range(0, 9);
        case (mix)
            MIX_GROW:   return (r < 4) ? ial_pkg::REQ_INSERT : (r < 7) ? ial_pkg::REQ_APPEND :
                               (r < 8) ? ial_pkg::REQ_ERASE : ial_pkg::REQ_READ;
            MIX_SHRINK: return (r < 1) ? ial_pkg::REQ_INSERT : (r < 2) ? ial_pkg::REQ_APPEND :
                               (r < 7) ? ial_pkg::REQ_ERASE : ial_pkg::REQ_READ;
            default:    return ial_pkg::req_t'($urandom_range(0, 3));
        endcase
    endfunction

    // Hard stop in case the block hangs.
    initial
    begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int            issued;
        int            span;
        mix_t          mix;
        ial_pkg::req_t kind;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = ial_pkg::REQ_INSERT;
        index    = '0;
        value    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, edges of the position range, all-zero and
        // all-one values, insert at front, middle and end, erase at each end.
        send_request(ial_pkg::REQ_READ,   7'd0,   32'h0);
        send_request(ial_pkg::REQ_ERASE,  7'd0,   32'h0);
        send_request(ial_pkg::REQ_INSERT, 7'd1,   32'h1234_5678);
        send_request(ial_pkg::REQ_INSERT, 7'd127, 32'hDEAD_BEEF);
        send_request(ial_pkg::REQ_APPEND, 7'd127, 32'hFFFF_FFFF);
        send_request(ial_pkg::REQ_INSERT, 7'd0,   32'h0000_0000);
        send_request(ial_pkg::REQ_INSERT, 7'd1,   32'hA5A5_A5A5);
        send_request(ial_pkg::REQ_INSERT, 7'd3,   32'h5A5A_5A5A);
        send_request(ial_pkg::REQ_INSERT, 7'd5,   32'h0BAD_0BAD);
        for (int i = 0; i < 4; i++)
            send_request(ial_pkg::REQ_READ, i[ial_pkg::INDEX_W-1:0], 32'h0);
        send_request(ial_pkg::REQ_READ,   7'd4,   32'h0);
        send_request(ial_pkg::REQ_READ,   7'd64,  32'h0);
        send_request(ial_pkg::REQ_ERASE,  7'd1,   32'h0);
        send_request(ial_pkg::REQ_ERASE,  7'd2,   32'h0);
        send_request(ial_pkg::REQ_ERASE,  7'd0,   32'h0);
        send_request(ial_pkg::REQ_READ,   7'd0,   32'h0);
        send_request(ial_pkg::REQ_ERASE,  7'd1,   32'h0);
        send_request(ial_pkg::REQ_ERASE,  7'd0,   32'h0);
        send_request(ial_pkg::REQ_READ,   7'd0,   32'h0);
        drain_results();

        // Random phases; each ends by draining every outstanding result.
        issued = 0;
        while (issued < RAND_ITEMS)
        begin
            mix  = mix_t'($urandom_range(0, 3));
            calm = ($urandom_range(0, 3) == 0);
            if (mix == MIX_FILL)
            begin
                // Fill to capacity, then push past it: past-end inserts must report a
                // bad position, the in-range insert and the append full; the read succeeds.
                while (shadow.count < LIST_CAP)
                begin
                    send_request(ial_pkg::REQ_APPEND, any_index(), pick_value());
                    issued++;
                end
                send_request(ial_pkg::REQ_INSERT, ial_pkg::INDEX_W'(LIST_CAP + 1),
                             pick_value());
                send_request(ial_pkg::REQ_INSERT,
                             ial_pkg::INDEX_W'($urandom_range(0, LIST_CAP)), pick_value());
                send_request(ial_pkg::REQ_APPEND, any_index(), pick_value());
                send_request(ial_pkg::REQ_INSERT, 7'd127, pick_value());
                send_request(ial_pkg::REQ_READ,
                             ial_pkg::INDEX_W'($urandom_range(0, LIST_CAP - 1)), 32'h0);
                issued += 5;
            end
            else
            begin
                span = $urandom_range(20, 80);
                repeat (span)
                begin
                    kind = pick_kind(mix);
                    send_request(kind, pick_index(kind), pick_value());
                    issued++;
                end
            end
            drain_results();
        end

        calm = 1'b0;
        drain_results();
        // Let any stray result show up before the verdict.
        repeat (20) @(posedge clk);

        if (shadow.fails == 0 && shadow.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/ial_pkg.sv
design/ial_ctrl.sv
design/ial_datapath.sv
design/indexed_array_list_top.sv
bench/tb_indexed_array_list_top.sv
